// ===== sv/sha256_byte_stream_hasher_unit_defines.svh =====
// assertion macros for the sha-256 byte stream hasher
// used by the top level; expects clk and rst in scope
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SHABSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SHABSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/shabsh_pkg.sv =====
// shared types, constants and round functions for the sha-256 hasher
// no dependencies
`default_nettype none

package shabsh_pkg;

  // control from the byte sequencer to the compression core
  typedef struct packed {
    logic load;   // shift one assembled word into the schedule window
    logic start;  // begin the 64 rounds on the window
    logic init;   // return chaining words to the initial values
  } core_ctl_t;

  // status back from the compression core
  typedef struct packed {
    logic busy;
    logic done;   // final add cycle, chaining words update at this edge
  } core_stat_t;

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [5:0] PAD_END       = 6'd56;
  localparam logic [5:0] LAST_FILL     = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  // initial hash values
  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    unique case (idx)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // big sigma on a
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // big sigma on e
  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // small sigmas for the message schedule
  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/shabsh_core.sv =====
// iterative sha-256 compression core: one round per cycle on a shared round unit
// holds the chaining words and the 16-word schedule window; uses shabsh_pkg
`default_nettype none

module shabsh_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire shabsh_pkg::core_ctl_t  ctl,
  input  wire logic [31:0]            word_in,
  input  wire logic [2:0]             rd_idx,
  output logic [31:0]                 rd_word,
  output shabsh_pkg::core_stat_t      stat
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  cstate_t     cstate;
  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [31:0] w     [16];
  logic [5:0]  rnd;

  logic [31:0] t1, t2, ch, maj, w_next;

  // round unit and schedule expansion
  always_comb begin
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + shabsh_pkg::bsig1(v[4]) + ch + shabsh_pkg::round_k(rnd) + w[0];
    t2     = shabsh_pkg::bsig0(v[0]) + maj;
    w_next = w[0] + shabsh_pkg::ssig0(w[1]) + w[9] + shabsh_pkg::ssig1(w[14]);
  end

  // digest read port
  assign rd_word   = chain[rd_idx];
  assign stat.busy = (cstate != C_IDLE);
  assign stat.done = (cstate == C_ADD);

  // sequencer, working variables, window and chaining words
  always_ff @(posedge clk) begin
    // schedule window shifts on a word load or on every round
    if (ctl.load || cstate == C_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= ctl.load ? word_in : w_next;
    end

    if (rst) begin
      cstate <= C_IDLE;
      rnd    <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= shabsh_pkg::init_word(3'(i));
      end
    end else begin
      unique case (cstate)
        C_IDLE: begin
          if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
              v[i] <= chain[i];
            end
            rnd    <= '0;
            cstate <= C_ROUND;
          end
        end
        C_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == shabsh_pkg::LAST_ROUND) begin
            cstate <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          cstate <= C_IDLE;
        end
        default: cstate <= C_IDLE;
      endcase
      // a new message starts from the initial values
      if (ctl.init) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= shabsh_pkg::init_word(3'(i));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
// sha-256 byte stream hasher: absorb takes one byte; a block-ending byte is then compressed
// (accept, 64 rounds on the shared round unit, final add). finish pushes up to 72 pad and
// length bytes one per cycle outside compressions, with a turn state at byte 56, waits for
// each compression (one or two), then loads the digest words one per cycle as output frees up.
// input stall is high from a finish or block-ending byte until that work is done.
// synchronous reset returns all control state and chaining words to initial values.
`default_nettype none
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  typedef enum logic [2:0] {S_IDLE, S_PAD0, S_ZERO, S_LEN, S_COMP, S_OUT} state_t;

  state_t      state;
  state_t      ret_state;
  logic [5:0]  fill;
  logic [23:0] acc;
  logic [63:0] byte_count;
  logic [63:0] len_bits;
  logic [2:0]  out_idx;

  logic                   push_en;
  logic [7:0]             push_byte;
  logic                   out_load;
  logic [31:0]            rd_word;
  shabsh_pkg::core_ctl_t  core_ctl;
  shabsh_pkg::core_stat_t core_stat;

  // byte source: message byte, pad marker, zero fill or length
  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'h00;
    unique case (state)
      S_IDLE: begin
        push_en   = in_valid && !mode;
        push_byte = data_byte;
      end
      S_PAD0: begin
        push_en   = 1'b1;
        push_byte = shabsh_pkg::PAD_BYTE;
      end
      S_ZERO: push_en = (fill != shabsh_pkg::PAD_END);
      S_LEN: begin
        push_en   = 1'b1;
        push_byte = len_bits[63:56];
      end
      default: push_en = 1'b0;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // core control
  always_comb begin
    core_ctl.load  = push_en && (fill[1:0] == 2'b11);
    core_ctl.start = push_en && (fill == shabsh_pkg::LAST_FILL);
    core_ctl.init  = out_load && (out_idx == shabsh_pkg::LAST_WORD_IDX);
  end

  shabsh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (core_ctl),
    .word_in ({acc, push_byte}),
    .rd_idx  (out_idx),
    .rd_word (rd_word),
    .stat    (core_stat)
  );

  // sequencer, byte assembly and output register
  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_byte};
    end
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      fill       <= '0;
      byte_count <= '0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      // output register holds until taken, refills on a load
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!mode) begin
              byte_count <= byte_count + 64'd1;
              if (fill == shabsh_pkg::LAST_FILL) begin
                state     <= S_COMP;
                ret_state <= S_IDLE;
              end
            end else begin
              len_bits <= {byte_count[60:0], 3'b000};
              state    <= S_PAD0;
            end
          end
        end
        S_PAD0: begin
          state <= (fill == shabsh_pkg::LAST_FILL) ? S_COMP : S_ZERO;
          ret_state <= S_ZERO;
        end
        S_ZERO: begin
          if (fill == shabsh_pkg::PAD_END) begin
            state <= S_LEN;
          end else if (fill == shabsh_pkg::LAST_FILL) begin
            state     <= S_COMP;
            ret_state <= S_ZERO;
          end
        end
        S_LEN: begin
          len_bits <= {len_bits[55:0], 8'h00};
          if (fill == shabsh_pkg::LAST_FILL) begin
            state     <= S_COMP;
            ret_state <= S_OUT;
          end
        end
        S_COMP: begin
          if (core_stat.done) begin
            state <= ret_state;
          end
        end
        S_OUT: begin
          if (out_load) begin
            digest_word <= rd_word;
            word_index  <= out_idx;
            last_word   <= (out_idx == shabsh_pkg::LAST_WORD_IDX);
            out_idx     <= out_idx + 3'd1;
            if (out_idx == shabsh_pkg::LAST_WORD_IDX) begin
              state      <= S_IDLE;
              byte_count <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SHABSH_ASSERT_NOW(a_ready_core_idle, !in_stall, !core_stat.busy, "request taken while core busy")
  `SHABSH_ASSERT_NOW(a_done_in_comp, core_stat.done, state == S_COMP, "core finished outside wait")
  `SHABSH_ASSERT_NOW(a_last_index, out_valid && last_word, word_index == shabsh_pkg::LAST_WORD_IDX, "last mark on wrong word")
  `SHABSH_ASSERT_NEXT(a_word_order, out_valid && !out_stall && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "digest words out of order")

endmodule

`default_nettype wire
